// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

endpackage

// ===== rtl/tcw_if.sv =====
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::KIND_W-1:0]  kind;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::ROW_W-1:0]   cell_row;
  logic [tcw_pkg::COL_W-1:0]   cell_col;

  modport source (output valid, kind, char_code, cell_row, cell_col, input ready);
  modport sink   (input valid, kind, char_code, cell_row, cell_col, output ready);
endinterface

interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::COL_W-1:0]   cursor_col;
  logic [tcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tcw_pkg::CHAR_W-1:0]  cell_char;
  logic [tcw_pkg::ATTR_W-1:0]  cell_attr;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Character-cell text console. The screen (ROWS x COLUMNS cells, attribute byte high,
// character byte low) lives in one RAM with a single write port, and every item gives
// exactly one result carrying the cursor after the item and, for a read on the screen, the cell.
// The block takes no new item until the result of the last has moved from the result
// register to the output register; a read goes through the RAM read register and
// then the result register. A clear rewrites the whole screen; a put that runs off the
// bottom row scrolls, copying one cell per cycle and then blanking the bottom row.
// After reset the block clears the screen to spaces with attribute 7 and takes no item
// meanwhile; cfg writes are taken at any time, and the attribute register changes only
// the cells written afterwards.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  localparam int N      = ROWS * COLUMNS;
  localparam int AW     = $clog2(N);
  localparam int XW     = $clog2(COLUMNS);
  localparam int YW     = $clog2(ROWS);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CLEAR  = 6'b000100,
    S_READ   = 6'b001000,
    S_SCROLL = 6'b010000,
    S_BLANK  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              cnt_r, cnt_nxt;
  logic [XW-1:0]              x_r, x_nxt;
  logic [YW-1:0]              y_r, y_nxt;
  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic                       rd_ok_r, rd_ok_nxt;

  logic                       res_valid_r, res_valid_nxt;
  logic [tcw_pkg::COL_W-1:0]  res_col_r, res_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]  res_row_r, res_row_nxt;
  logic [tcw_pkg::CHAR_W-1:0] res_char_r, res_char_nxt;
  logic [tcw_pkg::ATTR_W-1:0] res_attr_r, res_attr_nxt;

  logic                       out_valid_r;
  logic [tcw_pkg::COL_W-1:0]  out_col_r;
  logic [tcw_pkg::ROW_W-1:0]  out_row_r;
  logic [tcw_pkg::CHAR_W-1:0] out_char_r;
  logic [tcw_pkg::ATTR_W-1:0] out_attr_r;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                       in_acc, res_move, res_load;
  logic                       x_last, y_last, is_nl, adv, put_scroll;
  logic [XW-1:0]              put_x;
  logic [YW-1:0]              put_y;
  logic [AW-1:0]              cur_addr, rd_addr;
  logic                       rd_ok_in;
  logic [tcw_pkg::CELL_W-1:0] blank;

  assign in_ch.ready = (state_r == S_IDLE) && !res_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign res_move    = res_valid_r && (!out_valid_r || out_ch.ready);

  assign blank = {attr_r, tcw_pkg::CHAR_SPACE};

  // cursor advance for a put
  assign x_last     = (x_r == XW'(COLUMNS - 1));
  assign y_last     = (y_r == YW'(ROWS - 1));
  assign is_nl      = (in_ch.char_code == tcw_pkg::CHAR_NEWLINE);
  assign adv        = is_nl || x_last;
  assign put_x      = adv ? '0 : x_r + 1'b1;
  assign put_y      = (adv && !y_last) ? y_r + 1'b1 : y_r;
  assign put_scroll = adv && y_last;
  assign cur_addr   = AW'(y_r) * AW'(COLUMNS) + AW'(x_r);

  assign rd_ok_in = (32'(in_ch.cell_row) < ROWS) && (32'(in_ch.cell_col) < COLUMNS);
  assign rd_addr  = AW'(in_ch.cell_row) * AW'(COLUMNS) + AW'(in_ch.cell_col);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rd_ok_nxt     = rd_ok_r;
    res_valid_nxt = res_move ? 1'b0 : res_valid_r;
    res_col_nxt   = res_col_r;
    res_row_nxt   = res_row_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    res_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = blank;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r + AW'(COLUMNS);
    res_char_nxt  = res_char_r;

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
        if (cnt_r == AW'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.kind)
            tcw_pkg::KIND_PUT: begin
              if (!is_nl) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_r, in_ch.char_code};
              end
              x_nxt = put_x;
              y_nxt = put_y;
              if (put_scroll) begin
                cnt_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                res_load = 1'b1;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              x_nxt     = '0;
              y_nxt     = '0;
              cnt_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            tcw_pkg::KIND_READ: begin
              ram_re    = 1'b1;
              ram_raddr = rd_addr;
              rd_ok_nxt = rd_ok_in;
              state_nxt = S_READ;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR, S_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == AW'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
          res_load  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_READ: begin
        res_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        // read cell k+COLUMNS while the cell read last cycle lands at k-1
        ram_re = (cnt_r != AW'(COPY_N));
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_r == AW'(COPY_N)) begin
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_INIT;
      end
    endcase

    if (res_load) begin
      res_valid_nxt = 1'b1;
      res_col_nxt   = tcw_pkg::COL_W'(x_nxt);
      res_row_nxt   = tcw_pkg::ROW_W'(y_nxt);
      res_char_nxt  = '0;
      res_attr_nxt  = '0;
      if ((state_r == S_READ) && rd_ok_r) begin
        res_char_nxt = ram_rdata[tcw_pkg::CHAR_W-1:0];
        res_attr_nxt = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    res_col_r  <= res_col_nxt;
    res_row_r  <= res_row_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    if (res_move) begin
      out_col_r  <= res_col_r;
      out_row_r  <= res_row_r;
      out_char_r <= res_char_r;
      out_attr_r <= res_attr_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (N)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(x_r) < COLUMNS) && (32'(y_r) < ROWS))
    else $error("cursor out of screen");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && ram_we |-> in_acc && (in_ch.kind == tcw_pkg::KIND_PUT))
    else $error("screen write in idle without a put");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_move |=> res_valid_r && $stable(res_col_r) && $stable(res_char_r))
    else $error("pending result lost");

  a_scroll_then_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) && (state_nxt != S_SCROLL) |=> state_r == S_BLANK)
    else $error("scroll did not blank the bottom row");

endmodule
